[hdl/tva_pkg.sv]
// shared types and constants for the timed valve actuator
// no dependencies; imported by timed_valve_actuator and its testbench
package tva_pkg;

   localparam int TickWidth = 16;
   localparam int PosWidth  = 8;

   // request kind, carried in req_tuser
   localparam logic [1:0] FUNC_TICK  = 2'd0;
   localparam logic [1:0] FUNC_WRITE = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;

   localparam logic [2:0] LOC_VALVE = 3'd3;

   localparam logic [7:0] CMD_CLOSE = 8'd0;
   localparam logic [7:0] CMD_OPEN  = 8'd1;
   localparam logic [7:0] CMD_CYCLE = 8'd2;

   localparam logic [PosWidth-1:0] POS_CLOSED  = 8'd0;
   localparam logic [PosWidth-1:0] POS_OPEN    = 8'd1;
   localparam logic [PosWidth-1:0] POS_UNKNOWN = 8'd255;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   // csr register indexes
   localparam logic [1:0] REG_OPEN_TICKS  = 2'd0;
   localparam logic [1:0] REG_CLOSE_TICKS = 2'd1;
   localparam logic [1:0] REG_PAUSE_TICKS = 2'd2;

   localparam logic [TickWidth-1:0] OPEN_TICKS_RST  = 16'd10000;
   localparam logic [TickWidth-1:0] CLOSE_TICKS_RST = 16'd8000;
   localparam logic [TickWidth-1:0] PAUSE_TICKS_RST = 16'd1000;

   // request fields, highest bits first in req_tdata
   typedef struct packed {
      logic [4:0] pad;
      logic [7:0] command;
      logic [2:0] location;
   } req_data_type;

   // result fields, highest bits first in rsp_tdata
   typedef struct packed {
      logic [3:0]          pad;
      logic                busy_res;
      logic                enable_drive;
      logic                close_drive;
      logic                open_drive;
      logic [PosWidth-1:0] read_value;
   } rsp_data_type;

   // one result slot: flag plus data
   typedef struct packed {
      logic         status;
      rsp_data_type data;
   } rsp_item_type;

endpackage

[hdl/timed_valve_actuator.sv]
// timed valve actuator: tick/write/read requests drive open, close and enable pins
// depends on tva_pkg (types, codes, reset values)
//
// channel  | dir | handshake             | payload
// ---------+-----+-----------------------+-------------------------------------------
// req      | in  | req_tvalid/req_tready | tuser func, tdata location, command
// rsp      | out | rsp_tvalid/rsp_tready | tuser status, tdata read_value, pins, busy
// csr      | in  | csr_we                | csr_index, csr_wdata (write only)
//
// one request per cycle while req_tready is high; the result is registered in a slot
// the phase, counter and pin update is one pass of logic from the accepted request
// output side is a main slot plus a skid slot, so req_tready drops only when both hold
// a result, and it is a register (no combinational path from rsp_tready)
// synchronous active-high reset: idle phase, pins low, valve position unknown,
// tick lengths back to 10000 / 8000 / 1000
module timed_valve_actuator (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // location[2:0], command[10:3], zero[15:11]
   input  logic [1:0]  req_tuser,   // func[1:0]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // read_value[7:0], open_drive[8], close_drive[9],
                                    // enable_drive[10], busy_res[11], zero[15:12]
   output logic        rsp_tuser,   // status[0]
   // configuration writes
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import tva_pkg::*;

   // drive sequence phases
   typedef enum logic [2:0] {
      PH_IDLE,
      PH_OPENING,
      PH_CLOSING,
      PH_CYC_OPEN,
      PH_CYC_PAUSE,
      PH_CYC_CLOSE
   } phase_type;

   // configuration registers
   logic [TickWidth-1:0] open_ticks_ff;
   logic [TickWidth-1:0] close_ticks_ff;
   logic [TickWidth-1:0] pause_ticks_ff;

   // actuator state
   phase_type            phase_ff,   phase_in;
   logic [TickWidth-1:0] counter_ff, counter_in;
   logic [PosWidth-1:0]  pos_ff,     pos_in;
   logic                 open_ff,    open_in;
   logic                 close_ff,   close_in;
   logic                 enable_ff,  enable_in;

   // output slots
   logic         main_valid_ff;
   logic         skid_valid_ff;
   rsp_item_type main_item_ff;
   rsp_item_type skid_item_ff;
   rsp_item_type result_in;

   req_data_type req_fields;
   logic         req_accept;
   logic         rsp_accept;
   logic         status_in;
   logic [PosWidth-1:0] read_in;

   assign req_fields = req_data_type'(req_tdata);
   // ready only depends on the skid slot, which is a flop
   assign req_tready = !skid_valid_ff;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_accept = main_valid_ff && rsp_tready;

   assign rsp_tvalid = main_valid_ff;
   assign rsp_tdata  = main_item_ff.data;
   assign rsp_tuser  = main_item_ff.status;

   // single pass: next actuator state and result for the request on the port
   always_comb begin
      phase_in   = phase_ff;
      counter_in = counter_ff;
      pos_in     = pos_ff;
      open_in    = open_ff;
      close_in   = close_ff;
      enable_in  = enable_ff;
      status_in  = STATUS_OK;
      read_in    = '0;

      case (req_tuser)
         FUNC_TICK: begin
            if (phase_ff != PH_IDLE) begin
               if (counter_ff <= TickWidth'(1)) begin
                  // phase ends on this tick; a length of zero acts as one
                  counter_in = '0;
                  case (phase_ff)
                     PH_OPENING: begin
                        open_in  = 1'b0;
                        phase_in = PH_IDLE;
                     end
                     PH_CLOSING: begin
                        close_in = 1'b0;
                        phase_in = PH_IDLE;
                     end
                     PH_CYC_OPEN: begin
                        open_in    = 1'b0;
                        counter_in = pause_ticks_ff;
                        phase_in   = PH_CYC_PAUSE;
                     end
                     PH_CYC_PAUSE: begin
                        close_in   = 1'b1;
                        counter_in = close_ticks_ff;
                        phase_in   = PH_CYC_CLOSE;
                     end
                     PH_CYC_CLOSE: begin
                        close_in  = 1'b0;
                        enable_in = 1'b0;
                        pos_in    = POS_CLOSED;
                        phase_in  = PH_IDLE;
                     end
                     default: begin
                        phase_in = PH_IDLE;
                     end
                  endcase
               end else begin
                  counter_in = counter_ff - TickWidth'(1);
               end
            end
         end
         FUNC_WRITE: begin
            if (req_fields.location != LOC_VALVE) begin
               status_in = STATUS_ERR;
            end else if (phase_ff == PH_IDLE) begin
               // commands while busy and unknown codes are dropped silently
               case (req_fields.command)
                  CMD_CLOSE: begin
                     pos_in     = POS_CLOSED;
                     enable_in  = 1'b0;
                     open_in    = 1'b0;
                     close_in   = 1'b1;
                     counter_in = close_ticks_ff;
                     phase_in   = PH_CLOSING;
                  end
                  CMD_OPEN: begin
                     pos_in     = POS_OPEN;
                     enable_in  = 1'b1;
                     close_in   = 1'b0;
                     open_in    = 1'b1;
                     counter_in = open_ticks_ff;
                     phase_in   = PH_OPENING;
                  end
                  CMD_CYCLE: begin
                     enable_in  = 1'b1;
                     close_in   = 1'b0;
                     open_in    = 1'b1;
                     counter_in = open_ticks_ff;
                     phase_in   = PH_CYC_OPEN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         FUNC_READ: begin
            if (req_fields.location == LOC_VALVE) begin
               read_in = pos_ff;
            end else begin
               status_in = STATUS_ERR;
            end
         end
         default: begin
            // unused func code: no operation
         end
      endcase

      result_in.status            = status_in;
      result_in.data.pad          = '0;
      result_in.data.busy_res     = (phase_in != PH_IDLE);
      result_in.data.enable_drive = enable_in;
      result_in.data.close_drive  = close_in;
      result_in.data.open_drive   = open_in;
      result_in.data.read_value   = read_in;
   end

   // actuator state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         open_ticks_ff  <= OPEN_TICKS_RST;
         close_ticks_ff <= CLOSE_TICKS_RST;
         pause_ticks_ff <= PAUSE_TICKS_RST;
         phase_ff       <= PH_IDLE;
         counter_ff     <= '0;
         pos_ff         <= POS_UNKNOWN;
         open_ff        <= 1'b0;
         close_ff       <= 1'b0;
         enable_ff      <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_OPEN_TICKS:  open_ticks_ff  <= csr_wdata;
               REG_CLOSE_TICKS: close_ticks_ff <= csr_wdata;
               REG_PAUSE_TICKS: pause_ticks_ff <= csr_wdata;
               default: begin
                  // index beyond the register list
               end
            endcase
         end
         if (req_accept) begin
            phase_ff   <= phase_in;
            counter_ff <= counter_in;
            pos_ff     <= pos_in;
            open_ff    <= open_in;
            close_ff   <= close_in;
            enable_ff  <= enable_in;
         end
      end
   end

   // output slot valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (skid_valid_ff) begin
            // no new transfer here since ready is low; refill main from skid
            if (rsp_accept) begin
               skid_valid_ff <= 1'b0;
            end
         end else if (req_accept) begin
            if (main_valid_ff && !rsp_tready) begin
               skid_valid_ff <= 1'b1;
            end else begin
               main_valid_ff <= 1'b1;
            end
         end else if (rsp_accept) begin
            main_valid_ff <= 1'b0;
         end
      end
   end

   // output slot payload
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_accept) begin
            main_item_ff <= skid_item_ff;
         end
      end else if (req_accept) begin
         if (main_valid_ff && !rsp_tready) begin
            skid_item_ff <= result_in;
         end else begin
            main_item_ff <= result_in;
         end
      end
   end

`ifndef SYNTHESIS
   // the skid slot is only filled behind a held main slot
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid slot holds a result while main slot is empty");

   // motor drives are never both on
   assert property (@(posedge clock) disable iff (reset)
      !(open_ff && close_ff))
      else $error("open and close drives active together");

   // no motor drive outside a running sequence
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (!open_ff && !close_ff))
      else $error("motor drive active while idle");

   // every transfer in leaves a result waiting next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_tvalid)
      else $error("request transfer produced no result");
`endif

endmodule

[test/timed_valve_actuator_test.sv]
// testbench for timed_valve_actuator: valve open, close and cycle sequences,
// busy lockout, error status, tick lengths and stalls on both stream sides
// depends on tva_pkg and timed_valve_actuator
`timescale 1ns / 1ps

module timed_valve_actuator_test;
   import tva_pkg::*;

   // generous watchdog bound, in clock cycles
   localparam int CycleLimit = 1_000_000;

   // codes the package leaves out
   localparam logic [1:0]  FUNC_SPARE  = 2'd3;  // undefined request kind, a no-op
   localparam logic [1:0]  REG_UNUSED  = 2'd3;  // csr index past the register list
   localparam logic [2:0]  LOC_FIRST   = 3'd0;
   localparam logic [2:0]  LOC_LAST    = 3'd7;
   localparam logic [7:0]  CMD_IGNORED = 8'd3;  // first value that is no command
   localparam logic [7:0]  CMD_MAX     = 8'hFF;
   localparam logic [15:0] LEN_MAX     = 16'hFFFF;

   typedef enum logic [2:0] {
      VALVE_IDLE,
      VALVE_OPENING,
      VALVE_CLOSING,
      CYCLE_OPENING,
      CYCLE_PAUSING,
      CYCLE_CLOSING
   } valve_phase_type;

   // every input known from time zero
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = FUNC_TICK;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_index  = REG_OPEN_TICKS;
   logic [15:0] csr_wdata  = '0;

   // idling odds in percent, and a long receiver hold-off counted down below
   int unsigned req_idle_pct    = 0;
   int unsigned rsp_idle_pct    = 0;
   int unsigned rsp_hold_cycles = 0;

   int unsigned cycle_count    = 0;
   int unsigned mismatch_count = 0;

   // results predicted for accepted requests, oldest first
   rsp_item_type expected_rsp[$];

   // valve state as the block should hold it
   logic [15:0]     open_len, close_len, pause_len;
   valve_phase_type phase_q;
   logic [15:0]     count_q;
   logic [7:0]      position_q;
   logic            open_q, close_q, enable_q;

   timed_valve_actuator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5ns clock = ~clock;

   // ---------------------------------------------------------------------
   // valve predictor
   // ---------------------------------------------------------------------

   function automatic void valve_model_reset();
      open_len   = OPEN_TICKS_RST;
      close_len  = CLOSE_TICKS_RST;
      pause_len  = PAUSE_TICKS_RST;
      phase_q    = VALVE_IDLE;
      count_q    = '0;
      position_q = POS_UNKNOWN;
      open_q     = 1'b0;
      close_q    = 1'b0;
      enable_q   = 1'b0;
   endfunction

   // a phase ran out: drop its pin and move to what follows
   function automatic void advance_phase();
      case (phase_q)
         VALVE_OPENING: begin
            open_q  = 1'b0;
            phase_q = VALVE_IDLE;
         end
         VALVE_CLOSING: begin
            close_q = 1'b0;
            phase_q = VALVE_IDLE;
         end
         CYCLE_OPENING: begin
            // lengths load at phase start, so late csr writes land here
            open_q  = 1'b0;
            count_q = pause_len;
            phase_q = CYCLE_PAUSING;
         end
         CYCLE_PAUSING: begin
            close_q = 1'b1;
            count_q = close_len;
            phase_q = CYCLE_CLOSING;
         end
         CYCLE_CLOSING: begin
            close_q    = 1'b0;
            enable_q   = 1'b0;
            position_q = POS_CLOSED;
            phase_q    = VALVE_IDLE;
         end
         default: phase_q = VALVE_IDLE;
      endcase
   endfunction

   function automatic void valve_tick();
      if (phase_q == VALVE_IDLE) return;
      // a length of zero behaves like one
      if (count_q <= 16'd1) begin
         count_q = '0;
         advance_phase();
      end else begin
         count_q = count_q - 16'd1;
      end
   endfunction

   // valve commands only start from idle; everything else is dropped
   function automatic void valve_command(input logic [7:0] cmd);
      if (phase_q != VALVE_IDLE) return;
      case (cmd)
         CMD_CLOSE: begin
            position_q = POS_CLOSED;
            enable_q   = 1'b0;
            open_q     = 1'b0;
            close_q    = 1'b1;
            count_q    = close_len;
            phase_q    = VALVE_CLOSING;
         end
         CMD_OPEN: begin
            position_q = POS_OPEN;
            enable_q   = 1'b1;
            close_q    = 1'b0;
            open_q     = 1'b1;
            count_q    = open_len;
            phase_q    = VALVE_OPENING;
         end
         CMD_CYCLE: begin
            // position only changes when the close phase is over
            enable_q = 1'b1;
            close_q  = 1'b0;
            open_q   = 1'b1;
            count_q  = open_len;
            phase_q  = CYCLE_OPENING;
         end
         default: ;
      endcase
   endfunction

   function automatic rsp_item_type valve_predict(input logic [1:0] func,
                                                  input logic [2:0] loc,
                                                  input logic [7:0] cmd);
      rsp_item_type r;
      r = '0;
      case (func)
         FUNC_TICK:  valve_tick();
         FUNC_WRITE: begin
            if (loc == LOC_VALVE) valve_command(cmd);
            else r.status = STATUS_ERR;
         end
         FUNC_READ: begin
            if (loc == LOC_VALVE) r.data.read_value = position_q;
            else r.status = STATUS_ERR;
         end
         default: ;  // spare kind: answered ok, nothing changes
      endcase
      r.data.open_drive   = open_q;
      r.data.close_drive  = close_q;
      r.data.enable_drive = enable_q;
      r.data.busy_res     = (phase_q != VALVE_IDLE);
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // receiver, checker and watchdog
   // ---------------------------------------------------------------------

   // random stalls, or a solid hold-off while rsp_hold_cycles runs down
   always @(posedge clock) begin
      if (rsp_hold_cycles != 0) begin
         rsp_tready      <= 1'b0;
         rsp_hold_cycles <= rsp_hold_cycles - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   function automatic void compare_field(input string name, input int unsigned want,
                                         input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   // each result transfer against the oldest prediction
   always @(posedge clock) begin
      rsp_item_type want;
      rsp_data_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_rsp.size() == 0) begin
            $error("result transfer with no request outstanding");
            mismatch_count++;
         end else begin
            want = expected_rsp.pop_front();
            compare_field("status", 32'(want.status), 32'(rsp_tuser));
            compare_field("read_value", 32'(want.data.read_value),
                          32'(got.read_value));
            compare_field("open_drive", 32'(want.data.open_drive),
                          32'(got.open_drive));
            compare_field("close_drive", 32'(want.data.close_drive),
                          32'(got.close_drive));
            compare_field("enable_drive", 32'(want.data.enable_drive),
                          32'(got.enable_drive));
            compare_field("busy_res", 32'(want.data.busy_res), 32'(got.busy_res));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("timed_valve_actuator: mismatch");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // shared drivers
   // ---------------------------------------------------------------------

   // one request transfer; tvalid stays up afterwards so back-to-back
   // requests never lower and raise it in the same step
   task automatic send_req(input logic [1:0] func, input logic [2:0] loc,
                           input logic [7:0] cmd);
      req_data_type fields;
      fields          = '0;
      fields.command  = cmd;
      fields.location = loc;
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= fields;
      do @(posedge clock); while (!req_tready);
      expected_rsp.push_back(valve_predict(func, loc, cmd));
   endtask

   task automatic send_ticks(input int unsigned count);
      repeat (count) send_req(FUNC_TICK, LOC_VALVE, CMD_CLOSE);
   endtask

   // stop offering and let every outstanding result come back
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // only called with nothing in flight, so the model can follow at once
   task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (index)
         REG_OPEN_TICKS:  open_len  = value;
         REG_CLOSE_TICKS: close_len = value;
         REG_PAUSE_TICKS: pause_len = value;
         default: ;
      endcase
   endtask

   // mostly ticks and valve commands so sequences run to the end, some noise
   task automatic send_random_item();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 45)
         send_req(FUNC_TICK, 3'($urandom_range(7)), 8'($urandom_range(255)));
      else if (roll < 70)
         send_req(FUNC_WRITE, LOC_VALVE, 8'($urandom_range(CMD_CYCLE, CMD_CLOSE)));
      else if (roll < 85)
         send_req(FUNC_READ, LOC_VALVE, 8'($urandom_range(255)));
      else
         send_req(2'($urandom_range(3)), 3'($urandom_range(7)), 8'($urandom_range(255)));
   endtask

   // short lengths keep sequences finishing; zero and one are edge values
   function automatic logic [15:0] pick_length();
      int unsigned roll;
      roll = $urandom_range(9);
      if (roll == 0) return 16'd0;
      if (roll == 1) return 16'd1;
      if (roll <= 7) return 16'($urandom_range(6, 2));
      return 16'($urandom_range(60, 7));
   endfunction

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // position unknown after reset, error status off the valve register,
   // idle ticks, spare kind and non-commands change nothing
   task automatic test_idle_requests();
      send_req(FUNC_READ,  LOC_VALVE,        CMD_MAX);
      send_req(FUNC_TICK,  LOC_LAST,         CMD_MAX);
      send_req(FUNC_SPARE, LOC_LAST,         CMD_MAX);
      send_req(FUNC_READ,  LOC_FIRST,        CMD_CLOSE);
      send_req(FUNC_READ,  LOC_VALVE - 3'd1, CMD_CLOSE);
      send_req(FUNC_WRITE, LOC_LAST,         CMD_OPEN);
      send_req(FUNC_WRITE, LOC_FIRST,        CMD_CYCLE);
      send_req(FUNC_WRITE, LOC_VALVE,        CMD_IGNORED);
      send_req(FUNC_WRITE, LOC_VALVE,        CMD_MAX);
      send_req(FUNC_READ,  LOC_VALVE,        CMD_CLOSE);
      wait_for_results();
   endtask

   // open and close pulses, with every command locked out while busy
   task automatic test_open_close();
      write_reg(REG_OPEN_TICKS,  16'd3);
      write_reg(REG_CLOSE_TICKS, 16'd2);
      write_reg(REG_PAUSE_TICKS, 16'd1);
      write_reg(REG_UNUSED,      LEN_MAX);  // past the list: ignored
      send_req(FUNC_WRITE, LOC_VALVE, CMD_OPEN);
      send_req(FUNC_WRITE, LOC_VALVE, CMD_CLOSE);
      send_req(FUNC_WRITE, LOC_VALVE, CMD_CYCLE);
      send_req(FUNC_READ,  LOC_VALVE, CMD_CLOSE);
      send_ticks(3);
      send_req(FUNC_WRITE, LOC_VALVE, CMD_CLOSE);
      send_req(FUNC_WRITE, LOC_VALVE, CMD_OPEN);
      send_ticks(2);
      send_req(FUNC_READ,  LOC_VALVE, CMD_CLOSE);
      wait_for_results();
   endtask

   // zero lengths end on the next tick; the cycle leaves the valve closed
   task automatic test_cycle_zero_length();
      write_reg(REG_OPEN_TICKS,  16'd0);
      write_reg(REG_PAUSE_TICKS, 16'd0);
      write_reg(REG_CLOSE_TICKS, 16'd1);
      send_req(FUNC_WRITE, LOC_VALVE, CMD_OPEN);
      send_ticks(1);
      send_req(FUNC_WRITE, LOC_VALVE, CMD_CYCLE);
      send_req(FUNC_READ,  LOC_VALVE, CMD_CLOSE);
      send_ticks(3);
      send_req(FUNC_READ,  LOC_VALVE, CMD_CLOSE);
      wait_for_results();
   endtask

   // lengths rewritten mid-cycle apply to the phases not yet started
   task automatic test_reconfig_while_busy();
      write_reg(REG_OPEN_TICKS,  16'd2);
      write_reg(REG_PAUSE_TICKS, 16'd4);
      write_reg(REG_CLOSE_TICKS, 16'd3);
      send_req(FUNC_WRITE, LOC_VALVE, CMD_CYCLE);
      send_ticks(1);
      wait_for_results();
      write_reg(REG_PAUSE_TICKS, 16'd1);
      write_reg(REG_CLOSE_TICKS, 16'd5);
      send_ticks(8);
      send_req(FUNC_READ, LOC_VALVE, CMD_CLOSE);
      wait_for_results();
   endtask

   // receiver holds off long enough for the block to fill and stall its input
   task automatic test_input_stall();
      write_reg(REG_OPEN_TICKS,  16'd4);
      write_reg(REG_CLOSE_TICKS, 16'd3);
      write_reg(REG_PAUSE_TICKS, 16'd2);
      rsp_hold_cycles = 300;
      repeat (40) send_random_item();
      wait_for_results();
   endtask

   // random traffic in bursts; lengths change between bursts, often while
   // a sequence is still running
   task automatic test_random_traffic(input int unsigned req_pct,
                                      input int unsigned rsp_pct,
                                      input int unsigned item_count);
      int unsigned sent;
      int unsigned burst;
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
      sent         = 0;
      while (sent < item_count) begin
         wait_for_results();
         write_reg(REG_OPEN_TICKS,  pick_length());
         write_reg(REG_CLOSE_TICKS, pick_length());
         write_reg(REG_PAUSE_TICKS, pick_length());
         burst = $urandom_range(120, 40);
         repeat (burst) send_random_item();
         sent += burst;
      end
      wait_for_results();
   endtask

   // full-scale lengths load whole; the pulse is still running after a few
   // ticks, with the counter high bits set
   task automatic test_longest_pulse();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      write_reg(REG_OPEN_TICKS,  LEN_MAX);
      write_reg(REG_CLOSE_TICKS, LEN_MAX);
      write_reg(REG_PAUSE_TICKS, LEN_MAX);
      send_req(FUNC_WRITE, LOC_VALVE, CMD_OPEN);
      send_ticks(8);
      send_req(FUNC_READ, LOC_VALVE, CMD_CLOSE);  // still busy, open
      wait_for_results();
   endtask

   // ---------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------

   initial begin
      valve_model_reset();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // sender idles lightly, receiver heavily
      req_idle_pct = 31;
      rsp_idle_pct = 72;
      test_idle_requests();
      test_open_close();
      test_cycle_zero_length();
      test_reconfig_while_busy();
      test_input_stall();

      test_random_traffic(31, 72, 540);
      test_random_traffic(72, 31, 540);
      test_random_traffic(0, 0, 540);
      test_longest_pulse();

      wait_for_results();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("timed_valve_actuator: match");
      end else begin
         $display("timed_valve_actuator: mismatch");
      end
      $finish;
   end

endmodule
